// File: hw/rtl/sia_pkg.sv
// Slot index allocator package: command codes, status codes, FSM state,
// and the command/status structs between controller and datapath.
// No dependencies.
package sia_pkg;

	localparam int SLOT_W  = 8;
	localparam int CHUNK   = 16;   // bitmap bits examined per scan cycle
	localparam int CHUNK_W = 4;

	typedef enum logic [2:0] {
		CMD_ALLOC  = 3'd0,
		CMD_FREE   = 3'd1,
		CMD_LOOKUP = 3'd2,
		CMD_NEXT   = 3'd3,
		CMD_RESET  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NONE     = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP,
		S_SCAN,
		S_REPORT
	} state_t;

	typedef struct packed {
		logic capture;     // latch the input transfer
		logic exec;        // single-cycle operation on the captured command
		logic pop_req;     // pop the freed stack, read issued
		logic pop_finish;  // allocate the popped index
		logic scan_init;   // set up the next-live scan
		logic scan_step;   // examine one bitmap chunk
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic stack_empty;
		logic scan_done;
	} dp_stat_t;

endpackage

// File: hw/rtl/sia_ctrl.sv
// Slot index allocator controller: sequences each command through the datapath.
// Depends on sia_pkg.
module sia_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sia_pkg::dp_stat_t   stat,
	output sia_pkg::ctrl_cmd_t  ctl,
	output logic                busy,
	output logic                done
);
	import sia_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.cmd == CMD_ALLOC && !stat.stack_empty) state_d = S_POP;
				else if (stat.cmd == CMD_NEXT) state_d = S_SCAN;
				else state_d = S_REPORT;
			end
			S_POP: state_d = S_REPORT;
			S_SCAN: begin
				if (stat.scan_done) state_d = S_REPORT;
			end
			S_REPORT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			S_DECODE: begin
				if (stat.cmd == CMD_ALLOC && !stat.stack_empty) ctl.pop_req = 1'b1;
				else if (stat.cmd == CMD_NEXT) ctl.scan_init = 1'b1;
				else ctl.exec = 1'b1;
			end
			S_POP: ctl.pop_finish = 1'b1;
			S_SCAN: ctl.scan_step = !stat.scan_done;
			S_REPORT: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

// File: hw/rtl/sia_dp.sv
// Slot index allocator datapath: in-use bitmap, freed-index stack memory,
// bump and high-water counters, chunked next-live scan. Depends on sia_pkg.
module sia_dp #(
	parameter int SLOTS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sia_pkg::ctrl_cmd_t            ctl,
	output sia_pkg::dp_stat_t             stat,
	input  logic [2:0]                    cmd,
	input  logic [sia_pkg::SLOT_W-1:0]    slot,
	input  logic                          from_start,
	output logic [1:0]                    status,
	output logic [sia_pkg::SLOT_W-1:0]    result_slot,
	output logic                          live
);
	import sia_pkg::*;

	localparam int SW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int NW  = (SLOTS + CHUNK - 1) / CHUNK;
	localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
	localparam int NWP = 2 ** WIW;
	localparam int MW  = WIW + CHUNK_W;
	localparam int PW  = ((MW > SLOT_W) ? MW : SLOT_W) + 1;

	// captured transfer
	cmd_t              cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic              from_q;

	// allocator state
	logic [CHUNK-1:0]  map_q [NWP];
	logic [SLOT_W-1:0] stack_mem [SLOTS];
	logic [SLOT_W-1:0] rd_q;
	logic [CW-1:0]     fc_q;
	logic [CW-1:0]     bn_q;
	logic [SW-1:0]     hw_q;

	// scan state
	logic [WIW-1:0]    cur_q;
	logic [MW-1:0]     start_q;
	logic              scan_done_q;

	// results
	status_t           res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_live_q;

	// combinational controls
	logic              res_we;
	status_t           res_status_d;
	logic [SLOT_W-1:0] res_slot_d;
	logic              res_live_d;
	logic              map_set, map_clr, clear_all, push, bump;
	logic [SW-1:0]     alloc_idx;
	logic [MW-1:0]     set_pos, slot_pos, hw_pos, pos, hit_pos;
	logic              slot_in_range, slot_live, bump_full, rd_in_range;
	logic [PW-1:0]     scan_start;
	logic              start_ok;
	logic [CHUNK-1:0]  word, cand;
	logic [CHUNK_W-1:0] hit_off;
	logic              hit, last_word;

	assign slot_in_range = PW'(slot_q) < PW'(SLOTS);
	assign slot_pos      = MW'(slot_q);
	assign slot_live     = slot_in_range && map_q[slot_pos[MW-1:CHUNK_W]][slot_pos[CHUNK_W-1:0]];
	assign bump_full     = bn_q == CW'(SLOTS);
	assign rd_in_range   = PW'(rd_q) < PW'(SLOTS);
	assign hw_pos        = MW'(hw_q);
	assign set_pos       = MW'(alloc_idx);

	assign scan_start = from_q ? '0 : PW'(slot_q) + PW'(1);
	assign start_ok   = scan_start <= PW'(hw_q);

	// one bitmap chunk per cycle, bounded by start point and high-water mark
	assign word = map_q[cur_q];
	always_comb begin
		pos = '0;
		for (int i = 0; i < CHUNK; i++) begin
			pos     = {cur_q, CHUNK_W'(i)};
			cand[i] = word[i] && (pos >= start_q) && (pos <= hw_pos);
		end
	end

	always_comb begin
		hit_off = '0;
		for (int i = CHUNK - 1; i >= 0; i--) begin
			if (cand[i]) hit_off = CHUNK_W'(i);
		end
	end

	assign hit       = |cand;
	assign hit_pos   = {cur_q, hit_off};
	assign last_word = cur_q == hw_pos[MW-1:CHUNK_W];

	always_comb begin
		res_we       = 1'b0;
		res_status_d = ST_NONE;
		res_slot_d   = '0;
		res_live_d   = 1'b0;
		map_set      = 1'b0;
		map_clr      = 1'b0;
		clear_all    = 1'b0;
		push         = 1'b0;
		bump         = 1'b0;
		alloc_idx    = SW'(bn_q);
		if (ctl.exec) begin
			res_we = 1'b1;
			unique case (cmd_q)
				CMD_ALLOC: begin
					if (!bump_full) begin
						bump         = 1'b1;
						map_set      = 1'b1;
						res_status_d = ST_OK;
						res_slot_d   = SLOT_W'(alloc_idx);
						res_live_d   = 1'b1;
					end
				end
				CMD_FREE: begin
					if (slot_live && fc_q < CW'(SLOTS)) begin
						map_clr      = 1'b1;
						push         = 1'b1;
						res_status_d = ST_OK;
						res_slot_d   = slot_q;
					end else begin
						res_status_d = ST_BAD_FREE;
					end
				end
				CMD_LOOKUP: begin
					if (slot_live) begin
						res_status_d = ST_OK;
						res_slot_d   = slot_q;
						res_live_d   = 1'b1;
					end
				end
				CMD_RESET: begin
					clear_all    = 1'b1;
					res_status_d = ST_OK;
				end
				default: res_status_d = ST_NONE;
			endcase
		end else if (ctl.pop_finish) begin
			res_we    = 1'b1;
			alloc_idx = SW'(rd_q);
			if (rd_in_range) begin
				map_set      = 1'b1;
				res_status_d = ST_OK;
				res_slot_d   = rd_q;
				res_live_d   = 1'b1;
			end
		end else if (ctl.scan_init) begin
			res_we = !start_ok;
		end else if (ctl.scan_step) begin
			if (hit) begin
				res_we       = 1'b1;
				res_status_d = ST_OK;
				res_slot_d   = SLOT_W'(hit_pos);
				res_live_d   = 1'b1;
			end else if (last_word) begin
				res_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NWP; w++) map_q[w] <= '0;
			fc_q        <= '0;
			bn_q        <= '0;
			hw_q        <= '0;
			cur_q       <= '0;
			start_q     <= '0;
			scan_done_q <= 1'b0;
		end else begin
			if (clear_all) begin
				for (int w = 0; w < NWP; w++) map_q[w] <= '0;
				fc_q <= '0;
				bn_q <= '0;
				hw_q <= '0;
			end else begin
				if (map_set) begin
					map_q[set_pos[MW-1:CHUNK_W]][set_pos[CHUNK_W-1:0]] <= 1'b1;
					if (alloc_idx > hw_q) hw_q <= alloc_idx;
				end
				if (map_clr) map_q[slot_pos[MW-1:CHUNK_W]][slot_pos[CHUNK_W-1:0]] <= 1'b0;
				if (push) fc_q <= fc_q + 1'b1;
				else if (ctl.pop_req) fc_q <= fc_q - 1'b1;
				if (bump) bn_q <= bn_q + 1'b1;
			end
			if (ctl.scan_init) begin
				start_q     <= MW'(scan_start);
				cur_q       <= WIW'(scan_start >> CHUNK_W);
				scan_done_q <= !start_ok;
			end else if (ctl.scan_step) begin
				if (hit || last_word) scan_done_q <= 1'b1;
				else cur_q <= cur_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= cmd_t'(cmd);
			slot_q <= slot;
			from_q <= from_start;
		end
		if (push) stack_mem[SW'(fc_q)] <= slot_q;
		if (ctl.pop_req) rd_q <= stack_mem[SW'(fc_q - 1'b1)];
		if (res_we) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
			res_live_q   <= res_live_d;
		end
	end

	assign stat.cmd         = cmd_q;
	assign stat.stack_empty = fc_q == '0;
	assign stat.scan_done   = scan_done_q;

	assign status      = res_status_q;
	assign result_slot = res_slot_q;
	assign live        = res_live_q;

endmodule

// File: hw/rtl/slot_index_allocator_top.sv
// Slot index allocator: hands out, frees, looks up and scans slot indices
// of a fixed pool. Command channel in, one result per command out.
//
// Input: a command (cmd, slot, from_start) transfers on a rising edge with
// start high and busy low. busy stays high until the result has been shown.
// Output: done is high for exactly one cycle while status, result_slot and
// live carry the result; the receiver takes it at the end of that cycle and
// cannot hold it off. Results hold their value between strobes.
// States each command passes through after the transfer edge:
//   free, lookup, reset, bump alloc, unused codes: decode, then report
//   alloc from the freed stack: decode, pop, report; the pop state waits for the registered stack read
//   next live: decode, scan, report; scan walks k 16-slot bitmap chunks up to the
//   high-water mark (at most SLOTS/16)
// A new command may transfer the cycle after done.
// arst_n clears the bitmap, stack count, bump counter and high-water mark
// at once; the reset command does the same. Stack contents are only read
// below the stack count and need no clearing.
module slot_index_allocator_top #(
	parameter int SLOTS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 cmd,
	input  logic [sia_pkg::SLOT_W-1:0] slot,
	input  logic                       from_start,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [sia_pkg::SLOT_W-1:0] result_slot,
	output logic                       live
);
	import sia_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	sia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	sia_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.cmd         (cmd),
		.slot        (slot),
		.from_start  (from_start),
		.status      (status),
		.result_slot (result_slot),
		.live        (live)
	);

endmodule

// File: tb/sv/slot_index_allocator_top_tb.sv
// Testbench for slot_index_allocator_top: directed and random command traffic
// checked against a tracker of the slot pool (bitmap, freed stack, bump, peak).
// Depends on sia_pkg and the slot_index_allocator_top RTL.
module slot_index_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sia_pkg::*;

	localparam int POOL = 256;
	localparam int TARGET_ITEMS = 600;
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

	typedef enum {MODE_MIX, MODE_DRAIN, MODE_SCAN, MODE_NOISE} traffic_mode_t;

	typedef struct packed {
		logic [2:0]  cmd;
		status_t     status;
		logic [7:0]  slot;
		logic        live;
	} reply_t;

	class slot_pool_tracker;
		bit       in_use[POOL];
		bit [7:0] freed_stack[POOL];
		int       freed_cnt;
		int       bump_ptr;
		int       peak;
		reply_t   pending_replies[$];
		int       errors;

		function new();
			wipe();
			errors = 0;
		endfunction

		function void wipe();
			foreach (in_use[k])
				in_use[k] = 1'b0;
			freed_cnt = 0;
			bump_ptr  = 0;
			peak      = 0;
		endfunction

		function bit pool_full();
			return freed_cnt == 0 && bump_ptr >= POOL;
		endfunction

		function int pick_live();
			int hits[$];
			foreach (in_use[k])
				if (in_use[k])
					hits.push_back(k);
			if (hits.size() == 0)
				return -1;
			return hits[$urandom_range(hits.size() - 1)];
		endfunction

		// Called once per accepted transfer; updates the pool and queues the reply.
		function void note_command(logic [2:0] c, logic [7:0] s, logic fs);
			reply_t r;
			int     i;
			r.cmd    = c;
			r.status = ST_NONE;
			r.slot   = '0;
			r.live   = 1'b0;
			case (c)
				CMD_ALLOC: begin
					i = -1;
					if (freed_cnt > 0) begin
						freed_cnt--;
						i = freed_stack[freed_cnt];
					end else if (bump_ptr < POOL) begin
						i = bump_ptr;
						bump_ptr++;
					end
					if (i >= 0) begin
						in_use[i] = 1'b1;
						if (i > peak)
							peak = i;
						r.status = ST_OK;
						r.slot   = i[7:0];
						r.live   = 1'b1;
					end
				end
				CMD_FREE: begin
					if (in_use[s]) begin
						in_use[s] = 1'b0;
						freed_stack[freed_cnt] = s;
						freed_cnt++;
						r.status = ST_OK;
						r.slot   = s;
					end else begin
						r.status = ST_BAD_FREE;
					end
				end
				CMD_LOOKUP: begin
					if (in_use[s]) begin
						r.status = ST_OK;
						r.slot   = s;
						r.live   = 1'b1;
					end
				end
				CMD_NEXT: begin
					// start point past the last slot finds nothing
					i = fs ? 0 : int'(s) + 1;
					while (i <= peak && i < POOL && !in_use[i])
						i++;
					if (i <= peak && i < POOL) begin
						r.status = ST_OK;
						r.slot   = i[7:0];
						r.live   = 1'b1;
					end
				end
				CMD_RESET: begin
					wipe();
					r.status = ST_OK;
				end
				default: ;
			endcase
			pending_replies.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_result(logic [1:0] st, logic [7:0] rs, logic lv);
			reply_t want;
			if (pending_replies.size() == 0) begin
				report($sformatf("result with nothing pending: status=%0d slot=%0d live=%0b",
					st, rs, lv));
				return;
			end
			want = pending_replies.pop_front();
			if (st !== want.status)
				report($sformatf("cmd %0d status %0d, want %0d", want.cmd, st, want.status));
			if (rs !== want.slot)
				report($sformatf("cmd %0d result_slot %0d, want %0d", want.cmd, rs, want.slot));
			if (lv !== want.live)
				report($sformatf("cmd %0d live %0b, want %0b", want.cmd, lv, want.live));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] cmd = '0;
	logic [7:0] slot = '0;
	logic       from_start = 1'b0;
	logic       busy;
	logic       done;
	logic [1:0] status;
	logic [7:0] result_slot;
	logic       live;

	slot_pool_tracker pool;
	int               items_sent = 0;

	slot_index_allocator_top #(
		.SLOTS(POOL)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.slot       (slot),
		.from_start (from_start),
		.done       (done),
		.status     (status),
		.result_slot(result_slot),
		.live       (live)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			pool.check_result(status, result_slot, live);
	end

	task automatic send(logic [2:0] c, logic [7:0] s, logic fs);
		@(negedge clk);
		start      <= 1'b1;
		cmd        <= c;
		slot       <= s;
		from_start <= fs;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pool.note_command(c, s, fs);
		items_sent++;
	endtask

	// Hold off new transfers until every pending reply has come back.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pool.pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic idle_gap(bit quiet);
		int roll;
		int n;
		if (quiet)
			return;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			n = 0;
		else if (roll < 88)
			n = $urandom_range(1, 3);
		else if (roll < 97)
			n = $urandom_range(4, 12);
		else
			n = $urandom_range(20, 60);
		if (n == 0)
			return;
		@(negedge clk);
		start      <= 1'b0;
		cmd        <= 3'($urandom);
		slot       <= 8'($urandom);
		from_start <= 1'($urandom);
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic run_directed();
		send(CMD_ALLOC, 8'hFF, 1'b1);       // empty pool: bump gives 0
		send(CMD_LOOKUP, 8'd0, 1'b0);
		send(CMD_LOOKUP, 8'hFF, 1'b1);      // never allocated
		send(CMD_FREE, 8'hFF, 1'b0);        // free of unused slot
		send(CMD_NEXT, 8'hAA, 1'b1);        // scan from zero, inclusive
		send(CMD_NEXT, 8'd0, 1'b0);         // nothing above zero yet
		send(CMD_NEXT, 8'hFF, 1'b0);        // start point past the end
		send(CMD_ALLOC, 8'd0, 1'b0);
		send(CMD_ALLOC, 8'h55, 1'b0);
		send(CMD_FREE, 8'd1, 1'b1);
		send(CMD_FREE, 8'd1, 1'b0);         // double free
		send(CMD_ALLOC, 8'd0, 1'b0);        // reuse from freed stack
		send(CMD_NEXT, 8'd0, 1'b0);
		send(CMD_NEXT, 8'd2, 1'b0);         // beyond high-water mark
		send(CMD_UNUSED_FIRST, 8'hFF, 1'b1);
		send(CMD_UNUSED_MID, 8'h0F, 1'b0);
		send(CMD_UNUSED_LAST, 8'hF0, 1'b1);
		send(CMD_RESET, 8'h3C, 1'b1);
		send(CMD_LOOKUP, 8'd0, 1'b0);
		send(CMD_NEXT, 8'd0, 1'b1);
		send(CMD_FREE, 8'd0, 1'b0);
		send(CMD_ALLOC, 8'd0, 1'b0);        // bump restarts at zero
	endtask

	task automatic choose_command(input traffic_mode_t m, output logic [2:0] c,
			output logic [7:0] s, output logic fs);
		int roll;
		int l;
		roll = $urandom_range(0, 99);
		l    = pool.pick_live();
		s    = 8'($urandom);
		fs   = 1'($urandom);
		case (m)
			MODE_MIX: c = roll < 35 ? CMD_ALLOC : roll < 60 ? CMD_FREE :
				roll < 75 ? CMD_LOOKUP : roll < 96 ? CMD_NEXT :
				roll < 97 ? CMD_RESET : 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
			MODE_DRAIN: c = roll < 60 ? CMD_FREE : roll < 75 ? CMD_ALLOC :
				roll < 85 ? CMD_LOOKUP : CMD_NEXT;
			MODE_SCAN: c = roll < 50 ? CMD_NEXT : roll < 80 ? CMD_LOOKUP :
				roll < 90 ? CMD_ALLOC : CMD_FREE;
			default: c = roll < 30 ?
				3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)) : 3'($urandom);
		endcase
		if (m == MODE_NOISE || l < 0)
			return;
		if ((c == CMD_FREE || c == CMD_LOOKUP) && $urandom_range(0, 9) < 7)
			s = l[7:0];
		else if (c == CMD_NEXT && $urandom_range(0, 1) == 1)
			s = 8'(l - $urandom_range(0, 3));
	endtask

	task automatic run_random();
		traffic_mode_t m;
		logic [2:0]    c;
		logic [7:0]    s;
		logic          fs;
		int            len;
		int            roll;
		bit            quiet;
		bit            filled;
		filled = 1'b0;
		while (items_sent < TARGET_ITEMS) begin
			quiet = $urandom_range(0, 4) == 0;
			if (!filled && items_sent > 120) begin
				// run the pool dry, then hit it while full
				filled = 1'b1;
				while (!pool.pool_full()) begin
					if ($urandom_range(0, 9) < 8)
						send(CMD_ALLOC, 8'($urandom), 1'($urandom));
					else
						send($urandom_range(0, 1) ? CMD_LOOKUP : CMD_NEXT,
							8'($urandom), 1'($urandom));
					idle_gap(quiet);
				end
				repeat (3)
					send(CMD_ALLOC, 8'($urandom), 1'($urandom));
				send(CMD_NEXT, 8'hFE, 1'b0);
				send(CMD_NEXT, 8'hFF, 1'b0);
				wait_drained();
				continue;
			end
			roll = $urandom_range(0, 99);
			m    = roll < 45 ? MODE_MIX : roll < 70 ? MODE_DRAIN :
				roll < 92 ? MODE_SCAN : MODE_NOISE;
			len  = m == MODE_NOISE ? $urandom_range(4, 12) : $urandom_range(10, 50);
			repeat (len) begin
				choose_command(m, c, s, fs);
				send(c, s, fs);
				idle_gap(quiet);
			end
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end
	endtask

	initial begin
		pool = new();
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		wait_drained();
		run_random();
		wait_drained();
		repeat (40)
			@(posedge clk);
		if (pool.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
